// ===== src/eqd_pkg.sv =====
// ----------------------------------------------------------------------------
// eqd_pkg
// Shared types and defaults of the event queue with discard.
// ----------------------------------------------------------------------------
package eqd_pkg;

  localparam int DEPTH_DEF = 64;

  localparam logic [6:0]  CAPACITY_RST     = 7'd64;
  localparam logic [31:0] DISCARD_MASK_RST = 32'h8000_0000;

  localparam logic REG_CAPACITY     = 1'b0;
  localparam logic REG_DISCARD_MASK = 1'b1;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_APPEND = 8'b0000_0010,
    S_LINK   = 8'b0000_0100,
    S_WRD    = 8'b0000_1000,
    S_WCHK   = 8'b0001_0000,
    S_UNLINK = 8'b0010_0000,
    S_DRD    = 8'b0100_0000,
    S_DPOP   = 8'b1000_0000
  } state_t;

endpackage

// ===== src/event_queue_with_discard_top.sv =====
// ----------------------------------------------------------------------------
// event_queue_with_discard_top
// Bounded event queue kept as a doubly linked list in slot memories, with a
// drop-newest-discardable policy when full.
// ----------------------------------------------------------------------------
// Usage: raise start with kind and the event fields; the request is taken
// when busy is low. kind selects enqueue or dequeue. Exactly one result
// follows per request: done pulses for one cycle with done_ok,
// victim_dropped, the out_* handles and fill_level. The receiver cannot
// stall; results must be taken in the cycle done is high.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user
// only while idle; the block itself does not enforce this. A plain enqueue
// goes through append and link, a dequeue through read and pop; an empty
// dequeue, or a refused enqueue with an empty list, answers from idle. An
// enqueue on a full queue walks from the tail (memory read, then type check
// per visited entry), then unlinks, appends and links; a walk that finds
// nothing ends after its last check. One request is in flight at a time.
// Reset empties the list at once, with no clearing pass of slot memories.
// ----------------------------------------------------------------------------
module event_queue_with_discard_top #(
  parameter int DEPTH = eqd_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [31:0] event_type,
  input  logic [31:0] event_data,
  input  logic [31:0] free_handle,
  output logic        done,
  output logic        done_ok,
  output logic        victim_dropped,
  output logic [31:0] out_type,
  output logic [31:0] out_data,
  output logic [31:0] out_free_handle,
  output logic [6:0]  fill_level,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import eqd_pkg::*;

  localparam int SW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam int CW = (PW > 7) ? PW : 7;
  localparam logic [PW-1:0] NULLP = PW'(DEPTH);
  localparam logic [PW-1:0] ONE   = PW'(1);

  // slot memories
  logic [31:0]   type_mem [DEPTH];
  logic [31:0]   data_mem [DEPTH];
  logic [31:0]   rel_mem  [DEPTH];
  logic [PW-1:0] next_mem [DEPTH];
  logic [PW-1:0] prev_mem [DEPTH];
  logic [SW-1:0] spare_mem[DEPTH];

  state_t        state;
  logic [6:0]    capacity;
  logic [31:0]   discard_mask;
  logic [PW-1:0] head, tail, held, top, low_mark;
  logic [PW-1:0] slot, steps, vp, vn;
  logic          dropped;
  logic [31:0]   ev_type, ev_data, ev_free, vt, vd, vf;

  logic [31:0]   rd_type, rd_data, rd_free;
  logic [PW-1:0] rd_next, rd_prev;
  logic [SW-1:0] rd_spare;

  logic [CW-1:0] cap_ext, cap_eff;
  logic          has_room;
  logic [PW-1:0] top_m1, alloc_slot, app_slot, walk_next, steps_inc;
  logic          found;

  // next_mem write port
  logic          nx_we;
  logic [SW-1:0] nx_addr;
  logic [PW-1:0] nx_val;
  // prev_mem write port
  logic          pv_we;
  logic [SW-1:0] pv_addr;
  logic [PW-1:0] pv_val;

  assign busy = (state != S_IDLE);

  always_comb begin
    cap_ext = CW'(capacity);
    cap_eff = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
  end
  assign has_room = CW'(held) < cap_eff;

  // entries of the spare stack below the low mark were never pushed and
  // still hold their position as slot number
  assign top_m1     = top - ONE;
  assign alloc_slot = (top_m1 < low_mark) ? top_m1 : PW'(rd_spare);
  assign app_slot   = dropped ? slot : alloc_slot;
  assign found      = (rd_type & discard_mask) != 32'd0;
  assign walk_next  = rd_prev;
  assign steps_inc  = steps + ONE;

  always_comb begin
    nx_we = 1'b0; nx_addr = app_slot[SW-1:0]; nx_val = NULLP;
    pv_we = 1'b0; pv_addr = app_slot[SW-1:0]; pv_val = tail;
    case (state)
      S_APPEND: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
      S_LINK: begin
        nx_we   = (tail != NULLP);
        nx_addr = tail[SW-1:0];
        nx_val  = slot;
      end
      S_UNLINK: begin
        nx_we   = (vp != NULLP);
        nx_addr = vp[SW-1:0];
        nx_val  = vn;
        pv_we   = (vn != NULLP);
        pv_addr = vn[SW-1:0];
        pv_val  = vp;
      end
      S_DPOP: begin
        pv_we   = (rd_next != NULLP);
        pv_addr = rd_next[SW-1:0];
        pv_val  = NULLP;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_APPEND) begin
      type_mem[app_slot[SW-1:0]] <= ev_type;
      data_mem[app_slot[SW-1:0]] <= ev_data;
      rel_mem[app_slot[SW-1:0]]  <= ev_free;
    end
    if (nx_we) next_mem[nx_addr] <= nx_val;
    if (pv_we) prev_mem[pv_addr] <= pv_val;
    if (state == S_DPOP) spare_mem[top[SW-1:0]] <= slot[SW-1:0];
    rd_type  <= type_mem[slot[SW-1:0]];
    rd_data  <= data_mem[slot[SW-1:0]];
    rd_free  <= rel_mem[slot[SW-1:0]];
    rd_next  <= next_mem[slot[SW-1:0]];
    rd_prev  <= prev_mem[slot[SW-1:0]];
    rd_spare <= spare_mem[top_m1[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      capacity     <= CAPACITY_RST;
      discard_mask <= DISCARD_MASK_RST;
      head         <= NULLP;
      tail         <= NULLP;
      held         <= '0;
      top          <= NULLP;
      low_mark     <= NULLP;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY:     capacity     <= cfg_data[6:0];
          REG_DISCARD_MASK: discard_mask <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            ev_type <= event_type;
            ev_data <= event_data;
            ev_free <= free_handle;
            dropped <= 1'b0;
            vt <= '0; vd <= '0; vf <= '0;
            steps <= '0;
            if (kind == KIND_ENQ) begin
              if (has_room) begin
                state <= S_APPEND;
              end else if (held == '0 || tail == NULLP) begin
                done            <= 1'b1;
                done_ok         <= 1'b0;
                victim_dropped  <= 1'b0;
                out_type        <= '0;
                out_data        <= '0;
                out_free_handle <= '0;
                fill_level      <= 7'(held);
              end else begin
                slot  <= tail;
                state <= S_WRD;
              end
            end else begin
              if (held == '0 || head == NULLP) begin
                done            <= 1'b1;
                done_ok         <= 1'b0;
                victim_dropped  <= 1'b0;
                out_type        <= '0;
                out_data        <= '0;
                out_free_handle <= '0;
                fill_level      <= 7'(held);
              end else begin
                slot  <= head;
                state <= S_DRD;
              end
            end
          end
        end
        S_WRD: state <= S_WCHK;
        S_WCHK: begin
          if (found) begin
            dropped <= 1'b1;
            vt <= rd_type; vd <= rd_data; vf <= rd_free;
            vp <= rd_prev; vn <= rd_next;
            state <= S_UNLINK;
          end else if (walk_next == NULLP || steps_inc >= held) begin
            done            <= 1'b1;
            done_ok         <= 1'b0;
            victim_dropped  <= 1'b0;
            out_type        <= '0;
            out_data        <= '0;
            out_free_handle <= '0;
            fill_level      <= 7'(held);
            state           <= S_IDLE;
          end else begin
            slot  <= walk_next;
            steps <= steps_inc;
            state <= S_WRD;
          end
        end
        S_UNLINK: begin
          if (vp == NULLP) head <= vn;
          if (vn == NULLP) tail <= vp;
          state <= S_APPEND;
        end
        S_APPEND: begin
          slot <= app_slot;
          if (!dropped) begin
            top  <= top_m1;
            held <= held + ONE;
            if (top_m1 < low_mark) low_mark <= top_m1;
          end
          state <= S_LINK;
        end
        S_LINK: begin
          if (tail == NULLP) head <= slot;
          tail            <= slot;
          done            <= 1'b1;
          done_ok         <= 1'b1;
          victim_dropped  <= dropped;
          out_type        <= vt;
          out_data        <= vd;
          out_free_handle <= vf;
          fill_level      <= 7'(held);
          state           <= S_IDLE;
        end
        S_DRD: state <= S_DPOP;
        S_DPOP: begin
          head <= rd_next;
          if (rd_next == NULLP) tail <= NULLP;
          top             <= top + ONE;
          held            <= held - ONE;
          done            <= 1'b1;
          done_ok         <= 1'b1;
          victim_dropped  <= 1'b0;
          out_type        <= rd_type;
          out_data        <= rd_data;
          out_free_handle <= rd_free;
          fill_level      <= 7'(held - ONE);
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
